// ----- rtl/hsc_pkg.sv -----
`default_nettype none
package hsc_pkg;

	localparam int unsigned T_STAGES   = 3;
	localparam int unsigned H_STAGES   = 8;
	localparam int unsigned NUM_STAGES = T_STAGES + H_STAGES;

	localparam logic signed [31:0] FINE_OFFSET = 32'sd76800;
	localparam logic signed [31:0] P_ROUND     = 32'sd16384;
	localparam logic signed [31:0] R_OFFSET    = 32'sd32768;
	localparam logic signed [31:0] Q_OFFSET    = 32'sd2097152;
	localparam logic signed [31:0] Q_ROUND     = 32'sd8192;
	localparam logic signed [31:0] HUM_MAX     = 32'sd419430400;

	typedef enum logic [2:0] {
		REG_T1   = 3'd0,
		REG_T2   = 3'd1,
		REG_T3   = 3'd2,
		REG_H2   = 3'd3,
		REG_H4   = 3'd4,
		REG_H5   = 3'd5,
		REG_HB   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic        [15:0] t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic signed [15:0] h2;
		logic signed [11:0] h4;
		logic signed [11:0] h5;
		logic        [7:0]  h1;
		logic        [7:0]  h3;
		logic signed [7:0]  h6;
	} coeffs_t;

endpackage
`default_nettype wire

// ----- rtl/hsc_cfg_regs.sv -----
`default_nettype none
module hsc_cfg_regs (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [23:0]        cfg_wdata,
	output hsc_pkg::coeffs_t        coeffs
);

	hsc_pkg::coeffs_t coeffs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeffs_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hsc_pkg::REG_T1: coeffs_q.t1 <= cfg_wdata[15:0];
				hsc_pkg::REG_T2: coeffs_q.t2 <= $signed(cfg_wdata[15:0]);
				hsc_pkg::REG_T3: coeffs_q.t3 <= $signed(cfg_wdata[15:0]);
				hsc_pkg::REG_H2: coeffs_q.h2 <= $signed(cfg_wdata[15:0]);
				hsc_pkg::REG_H4: coeffs_q.h4 <= $signed(cfg_wdata[11:0]);
				hsc_pkg::REG_H5: coeffs_q.h5 <= $signed(cfg_wdata[11:0]);
				hsc_pkg::REG_HB: begin
					coeffs_q.h1 <= cfg_wdata[7:0];
					coeffs_q.h3 <= cfg_wdata[15:8];
					coeffs_q.h6 <= $signed(cfg_wdata[23:16]);
				end
				default: ;
			endcase
		end
	end

	assign coeffs = coeffs_q;

endmodule
`default_nettype wire

// ----- rtl/hsc_pipe_ctrl.sv -----
`default_nettype none
module hsc_pipe_ctrl (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [hsc_pkg::NUM_STAGES-1:0]      en
);

	logic [hsc_pkg::NUM_STAGES-1:0] vld_q;
	logic [hsc_pkg::NUM_STAGES-1:0] vld_in;

	always_comb begin
		en[hsc_pkg::NUM_STAGES-1] = !vld_q[hsc_pkg::NUM_STAGES-1] | out_ready;
		for (int i = hsc_pkg::NUM_STAGES - 2; i >= 0; i--) begin
			en[i] = !vld_q[i] | en[i+1];
		end
	end

	assign vld_in = {vld_q[hsc_pkg::NUM_STAGES-2:0], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < hsc_pkg::NUM_STAGES; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_in[i];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[hsc_pkg::NUM_STAGES-1];

endmodule
`default_nettype wire

// ----- rtl/hsc_temp_pipe.sv -----
`default_nettype none
module hsc_temp_pipe (
	input  wire logic                         clk,
	input  wire logic [hsc_pkg::T_STAGES-1:0] en,
	input  wire hsc_pkg::coeffs_t             coeffs,
	input  wire logic [19:0]                  raw_temperature,
	input  wire logic [15:0]                  raw_humidity,
	output logic signed [31:0]                fine_s3,
	output logic signed [31:0]                x_s3,
	output logic [15:0]                       adc_h_s3
);

	logic signed [31:0] diff_a;
	logic signed [31:0] diff_d;
	logic signed [31:0] t2_ext;
	logic signed [31:0] t3_ext;
	logic signed [31:0] fine_next;

	logic signed [31:0] prod_a_s1;
	logic signed [31:0] dd_s1;
	logic [15:0]        adc_h_s1;
	logic signed [31:0] a_s2;
	logic signed [31:0] bp_s2;
	logic [15:0]        adc_h_s2;

	assign t2_ext = $signed({{16{coeffs.t2[15]}}, coeffs.t2});
	assign t3_ext = $signed({{16{coeffs.t3[15]}}, coeffs.t3});
	assign diff_a = $signed({15'd0, raw_temperature[19:3]} - {15'd0, coeffs.t1, 1'b0});
	assign diff_d = $signed({16'd0, raw_temperature[19:4]} - {16'd0, coeffs.t1});

	always_ff @(posedge clk) begin
		if (en[0]) begin
			prod_a_s1 <= diff_a * t2_ext;
			dd_s1     <= diff_d * diff_d;
			adc_h_s1  <= raw_humidity;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			a_s2     <= prod_a_s1 >>> 11;
			bp_s2    <= (dd_s1 >>> 12) * t3_ext;
			adc_h_s2 <= adc_h_s1;
		end
	end

	assign fine_next = a_s2 + (bp_s2 >>> 14);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			fine_s3  <= fine_next;
			x_s3     <= fine_next - hsc_pkg::FINE_OFFSET;
			adc_h_s3 <= adc_h_s2;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/hsc_hum_pipe.sv -----
`default_nettype none
module hsc_hum_pipe (
	input  wire logic                         clk,
	input  wire logic [hsc_pkg::H_STAGES-1:0] en,
	input  wire hsc_pkg::coeffs_t             coeffs,
	input  wire logic signed [31:0]           fine_in,
	input  wire logic signed [31:0]           x_in,
	input  wire logic [15:0]                  adc_h_in,
	output logic signed [31:0]                fine_temperature,
	output logic [16:0]                       relative_humidity
);

	logic signed [31:0] h1_ext;
	logic signed [31:0] h2_ext;
	logic signed [31:0] h3_ext;
	logic signed [31:0] h4_shl;
	logic signed [31:0] h5_ext;
	logic signed [31:0] h6_ext;
	logic signed [31:0] adc_h_shl;
	logic signed [31:0] res;

	logic signed [31:0] fine_s4, fine_s5, fine_s6, fine_s7;
	logic signed [31:0] fine_s8, fine_s9, fine_s10, fine_s11;
	logic signed [31:0] m5_s4, mq_s4, mr_s4;
	logic [15:0]        adc_h_s4;
	logic signed [31:0] p_s5, q1_s5, r_s5;
	logic signed [31:0] p_s6, qr_s6;
	logic signed [31:0] p_s7, qh_s7;
	logic signed [31:0] x2_s8;
	logic signed [31:0] x2_s9, ss_s9;
	logic signed [31:0] x2_s10, sh_s10;
	logic [16:0]        rh_s11;

	assign h1_ext    = $signed({24'd0, coeffs.h1});
	assign h2_ext    = $signed({{16{coeffs.h2[15]}}, coeffs.h2});
	assign h3_ext    = $signed({24'd0, coeffs.h3});
	assign h4_shl    = $signed({coeffs.h4, 20'd0});
	assign h5_ext    = $signed({{20{coeffs.h5[11]}}, coeffs.h5});
	assign h6_ext    = $signed({{24{coeffs.h6[7]}}, coeffs.h6});
	assign adc_h_shl = $signed({2'd0, adc_h_s4, 14'd0});

	always_ff @(posedge clk) begin
		if (en[0]) begin
			m5_s4    <= h5_ext * x_in;
			mq_s4    <= x_in * h6_ext;
			mr_s4    <= x_in * h3_ext;
			adc_h_s4 <= adc_h_in;
			fine_s4  <= fine_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			p_s5    <= (adc_h_shl - h4_shl - m5_s4 + hsc_pkg::P_ROUND) >>> 15;
			q1_s5   <= mq_s4 >>> 10;
			r_s5    <= (mr_s4 >>> 11) + hsc_pkg::R_OFFSET;
			fine_s5 <= fine_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			qr_s6   <= q1_s5 * r_s5;
			p_s6    <= p_s5;
			fine_s6 <= fine_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			qh_s7   <= ((qr_s6 >>> 10) + hsc_pkg::Q_OFFSET) * h2_ext;
			p_s7    <= p_s6;
			fine_s7 <= fine_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			x2_s8   <= p_s7 * ((qh_s7 + hsc_pkg::Q_ROUND) >>> 14);
			fine_s8 <= fine_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			ss_s9   <= (x2_s8 >>> 15) * (x2_s8 >>> 15);
			x2_s9   <= x2_s8;
			fine_s9 <= fine_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			sh_s10   <= (ss_s9 >>> 7) * h1_ext;
			x2_s10   <= x2_s9;
			fine_s10 <= fine_s9;
		end
	end

	assign res = x2_s10 - (sh_s10 >>> 4);

	always_ff @(posedge clk) begin
		if (en[7]) begin
			if (res < 32'sd0) begin
				rh_s11 <= '0;
			end else if (res > hsc_pkg::HUM_MAX) begin
				rh_s11 <= hsc_pkg::HUM_MAX[28:12];
			end else begin
				rh_s11 <= res[28:12];
			end
			fine_s11 <= fine_s10;
		end
	end

	assign fine_temperature  = fine_s11;
	assign relative_humidity = rh_s11;

endmodule
`default_nettype wire

// ----- rtl/humidity_sensor_compensation.sv -----
// An accepted input transaction passes every stage before out_valid; a stall holds it longer.
// One transaction per cycle unless stalled; each of 11 stages has at most one multiply level.
// A stall at the output backs up only as far as the first empty stage.
// Reset (arst_n low, asynchronous) empties the pipeline and clears all coefficients to 0.
`default_nettype none
module humidity_sensor_compensation (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [19:0]        raw_temperature,
	input  wire logic [15:0]        raw_humidity,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      fine_temperature,
	output logic [16:0]             relative_humidity,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [23:0]        cfg_wdata
);

	hsc_pkg::coeffs_t                  coeffs;
	logic [hsc_pkg::NUM_STAGES-1:0]    en;
	logic signed [31:0]                fine_s3;
	logic signed [31:0]                x_s3;
	logic [15:0]                       adc_h_s3;

	hsc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.coeffs    (coeffs)
	);

	hsc_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.en        (en)
	);

	hsc_temp_pipe u_temp (
		.clk             (clk),
		.en              (en[hsc_pkg::T_STAGES-1:0]),
		.coeffs          (coeffs),
		.raw_temperature (raw_temperature),
		.raw_humidity    (raw_humidity),
		.fine_s3         (fine_s3),
		.x_s3            (x_s3),
		.adc_h_s3        (adc_h_s3)
	);

	hsc_hum_pipe u_hum (
		.clk               (clk),
		.en                (en[hsc_pkg::NUM_STAGES-1:hsc_pkg::T_STAGES]),
		.coeffs            (coeffs),
		.fine_in           (fine_s3),
		.x_in              (x_s3),
		.adc_h_in          (adc_h_s3),
		.fine_temperature  (fine_temperature),
		.relative_humidity (relative_humidity)
	);

endmodule
`default_nettype wire

// ----- rtl/hsc_checker.sv -----
`default_nettype none
module hsc_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic [19:0]        raw_temperature,
	input wire logic [15:0]        raw_humidity,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic signed [31:0] fine_temperature,
	input wire logic [16:0]        relative_humidity,
	input wire logic               cfg_we,
	input wire logic [2:0]         cfg_index,
	input wire logic [23:0]        cfg_wdata
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(fine_temperature)
			&& $stable(relative_humidity))
		else $error("stalled output transaction changed");

	a_rh_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> relative_humidity <= 17'd102400)
		else $error("humidity out of range");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output stage");

endmodule

bind humidity_sensor_compensation hsc_checker u_hsc_checker (.*);
`default_nettype wire

// ----- tb/tb.sv -----
module tb;
	import hsc_pkg::*;

	localparam logic [2:0]  REG_UNUSED  = 3'd7;
	localparam logic [19:0] T_TOP       = 20'hFFFFF;
	localparam logic [15:0] H_TOP       = 16'hFFFF;
	localparam int          SETTLE      = 2 * NUM_STAGES + 8;
	localparam int          LONG_HOLD   = 300;
	localparam int          QUIET_LIMIT = 4000;
	localparam int          RANDOM_PHASES = 8;
	localparam int          PHASE_ITEMS = 125;

	typedef enum {CAL_NOMINAL, CAL_JITTER, CAL_RANDOM, CAL_TOP, CAL_BOTTOM, CAL_CORNERS}
		cal_style_t;

	typedef struct {
		logic signed [31:0] fine_temp;
		logic [16:0]        humidity;
	} reading_t;

	class compensation_book;
		coeffs_t  cal = '0;
		reading_t expected_readings[$];
		int       mismatches = 0;
		int       checked = 0;

		function void write_reg(logic [2:0] idx, logic [23:0] data);
			case (idx)
				REG_T1: cal.t1 = data[15:0];
				REG_T2: cal.t2 = data[15:0];
				REG_T3: cal.t3 = data[15:0];
				REG_H2: cal.h2 = data[15:0];
				REG_H4: cal.h4 = data[11:0];
				REG_H5: cal.h5 = data[11:0];
				REG_HB: begin
					cal.h1 = data[7:0];
					cal.h3 = data[15:8];
					cal.h6 = data[23:16];
				end
				default: ;
			endcase
		endfunction

		function reading_t compensate(logic [19:0] adc_t, logic [15:0] adc_h);
			int t1, t2, t3, h1, h2, h3, h4, h5, h6;
			int a, b, d, fine, x, p, q, r;
			reading_t res;
			t1 = int'(cal.t1);
			t2 = int'($signed(cal.t2));
			t3 = int'($signed(cal.t3));
			h1 = int'(cal.h1);
			h2 = int'($signed(cal.h2));
			h3 = int'(cal.h3);
			h4 = int'($signed(cal.h4));
			h5 = int'($signed(cal.h5));
			h6 = int'($signed(cal.h6));
			a = ((int'(adc_t >> 3) - (t1 <<< 1)) * t2) >>> 11;
			d = int'(adc_t >> 4) - t1;
			b = (((d * d) >>> 12) * t3) >>> 14;
			fine = a + b;
			x = fine - 76800;
			p = ((int'(adc_h) <<< 14) - (h4 <<< 20) - (h5 * x) + 16384) >>> 15;
			q = (x * h6) >>> 10;
			r = ((x * h3) >>> 11) + 32768;
			q = ((q * r) >>> 10) + 2097152;
			q = ((q * h2) + 8192) >>> 14;
			x = p * q;
			r = ((((x >>> 15) * (x >>> 15)) >>> 7) * h1) >>> 4;
			x = x - r;
			if (x < 0)
				x = 0;
			if (x > 419430400)
				x = 419430400;
			res.fine_temp = fine;
			res.humidity = 17'(x >>> 12);
			return res;
		endfunction

		function void note(logic [19:0] adc_t, logic [15:0] adc_h);
			expected_readings.push_back(compensate(adc_t, adc_h));
		endfunction

		function void check(logic signed [31:0] fine_temp, logic [16:0] humidity);
			reading_t want;
			if (expected_readings.size() == 0) begin
				$display("%0t: result with nothing pending: fine_temperature %0d, relative_humidity %0d",
					$time, fine_temp, humidity);
				mismatches++;
				return;
			end
			want = expected_readings.pop_front();
			checked++;
			if (fine_temp !== want.fine_temp) begin
				$display("%0t: fine_temperature expected %0d, actual %0d",
					$time, want.fine_temp, fine_temp);
				mismatches++;
			end
			if (humidity !== want.humidity) begin
				$display("%0t: relative_humidity expected %0d, actual %0d",
					$time, want.humidity, humidity);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_readings.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [19:0]        raw_temperature;
	logic [15:0]        raw_humidity;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] fine_temperature;
	logic [16:0]        relative_humidity;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [23:0]        cfg_wdata;

	compensation_book book = new();
	bit steady;
	bit squeeze;
	int calibrations;
	int quiet_cycles;
	int stall_run;
	int longest_stall;

	humidity_sensor_compensation u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.raw_temperature   (raw_temperature),
		.raw_humidity      (raw_humidity),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.fine_temperature  (fine_temperature),
		.relative_humidity (relative_humidity),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int jit(int base, int span);
		return base + int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic logic [23:0] nominal_word(int idx, int s);
		case (idx)
			REG_T1: return 24'(jit(27504, 3000 * s));
			REG_T2: return 24'(jit(26435, 3000 * s));
			REG_T3: return 24'(jit(-1000, 2000 * s));
			REG_H2: return 24'(jit(362, 150 * s));
			REG_H4: return 24'(jit(313, 150 * s));
			REG_H5: return 24'(jit(50, 50 * s));
			default: return {8'(jit(30, 30 * s)), 8'(jit(20, 20 * s)), 8'(jit(75, 75 * s))};
		endcase
	endfunction

	function automatic logic [23:0] extreme_word(int idx, bit upper);
		logic [23:0] pat;
		logic [23:0] mask;
		int width;
		width = 16;
		case (idx)
			REG_T1: pat = upper ? 24'h00FFFF : 24'h000000;
			REG_T2, REG_T3, REG_H2: pat = upper ? 24'h007FFF : 24'h008000;
			REG_H4, REG_H5: begin
				pat = upper ? 24'h0007FF : 24'h000800;
				width = 12;
			end
			default: begin
				pat = upper ? 24'h7FFFFF : 24'h800000;
				width = 24;
			end
		endcase
		mask = (24'h1 << width) - 24'h1;
		return pat | (24'($urandom) & ~mask);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				book.note(raw_temperature, raw_humidity);
			if (out_valid && out_ready)
				book.check(fine_temperature, relative_humidity);
			if (in_valid && !in_ready)
				stall_run++;
			else
				stall_run = 0;
			if (stall_run > longest_stall)
				longest_stall = stall_run;
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin : receiver
		int hold;
		int run;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (squeeze) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				squeeze = 1'b0;
			end
			hold = steady ? 0 : pick_gap();
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			run = $urandom_range(1, 12);
			out_ready <= 1'b1;
			repeat (run) @(negedge clk);
		end
	end

	task automatic set_reg(input logic [2:0] idx, input logic [23:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		book.write_reg(idx, data);
		@(negedge clk);
	endtask

	task automatic load_calibration(input cal_style_t style);
		logic [23:0] word;
		for (int i = REG_T1; i <= REG_HB; i++) begin
			case (style)
				CAL_NOMINAL: word = nominal_word(i, 0);
				CAL_JITTER:  word = nominal_word(i, 1);
				CAL_RANDOM:  word = 24'($urandom);
				CAL_TOP:     word = extreme_word(i, 1'b1);
				CAL_BOTTOM:  word = extreme_word(i, 1'b0);
				default:     word = extreme_word(i, 1'($urandom));
			endcase
			set_reg(3'(i), word);
		end
		set_reg(REG_UNUSED, 24'($urandom));
		calibrations++;
	endtask

	task automatic offer(input logic [19:0] t, input logic [15:0] h);
		int gap;
		in_valid <= 1'b1;
		raw_temperature <= t;
		raw_humidity <= h;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic offer_random_reading();
		if ($urandom_range(0, 9) < 7)
			offer(20'($urandom_range(380000, 680000)), 16'($urandom_range(10000, 55000)));
		else
			offer(20'($urandom), 16'($urandom));
	endtask

	task automatic offer_corners();
		offer('0, '0);
		offer('0, H_TOP);
		offer(T_TOP, '0);
		offer(T_TOP, H_TOP);
		offer(20'd519888, 16'd27000);
	endtask

	task automatic settle_pipeline();
		in_valid <= 1'b0;
		while (book.pending() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	initial begin : stimulus
		cal_style_t style;
		in_valid = 1'b0;
		raw_temperature = '0;
		raw_humidity = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		steady = 1'b0;
		squeeze = 1'b0;
		calibrations = 0;
		quiet_cycles = 0;
		stall_run = 0;
		longest_stall = 0;
		arst_n = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		offer('0, '0);
		offer(T_TOP, H_TOP);
		settle_pipeline();

		load_calibration(CAL_NOMINAL);
		offer(20'd519888, 16'd27000);
		offer(20'd519888, '0);
		offer(20'd519888, H_TOP);
		offer(20'd415000, 16'd38000);
		offer(20'd640000, 16'd21000);
		offer(T_TOP, '0);
		settle_pipeline();

		load_calibration(CAL_TOP);
		offer_corners();
		settle_pipeline();

		load_calibration(CAL_BOTTOM);
		offer_corners();
		settle_pipeline();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph % 4 == 1)
				style = CAL_RANDOM;
			else if (ph % 4 == 3)
				style = CAL_CORNERS;
			else
				style = CAL_JITTER;
			load_calibration(style);
			steady = (ph == 2 || ph == 4);
			squeeze = (ph == 4);
			repeat (PHASE_ITEMS) offer_random_reading();
			steady = 1'b0;
			settle_pipeline();
		end

		$display("Checked %0d compensated readings across %0d calibration sets,",
			book.checked, calibrations);
		$display("including clamped, wrapped and masked cases; longest input stall %0d cycles.",
			longest_stall);
		if (book.mismatches == 0 && book.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
